// ===== rtl/uart8n1_pkg.sv =====
// constants and widths shared by the 8n1 uart core
package uart8n1_pkg;

  localparam int unsigned DATA_BITS    = 8;
  localparam int unsigned BYTE_W       = 8;
  localparam int unsigned PERIOD_W     = 24;
  localparam int unsigned ACC_W        = 28;
  localparam int unsigned COUNT_W      = 20;
  localparam int unsigned INDEX_W      = 4;
  localparam int unsigned IN_DATA_W    = 16;
  localparam int unsigned OUT_DATA_W   = 16;

  localparam logic [PERIOD_W-1:0] PERIOD_RESET = 24'd35556;
  localparam logic [PERIOD_W-1:0] PERIOD_MIN   = 24'd256;

  localparam logic [INDEX_W-1:0] START_INDEX   = 4'd0;
  localparam logic [INDEX_W-1:0] LAST_DATA_IDX = INDEX_W'(DATA_BITS);
  localparam logic [INDEX_W-1:0] STOP_INDEX    = INDEX_W'(DATA_BITS + 1);

endpackage

// ===== rtl/uart_8n1_tx_rx_fractional_baud_core.sv =====
// 8n1 uart transmitter and receiver with fractional bit timing, one tick per request
// Each accepted input request is one clock tick of the bit timer: tx_start and tx_byte
// feed the transmitter, rx_line the receiver, and both run independently. A request is
// taken every cycle while the output register is empty or being drained; the result for
// that tick is visible in the output register in the cycle after the request is taken.
// The timing logic is one 20-bit count compare and one 28-bit boundary add per side.
// bit_period_q8 is cycles per bit in unsigned 16.8 fixed point (values below 1.0 act as
// 1.0); bit k of a frame ends floor(k * period) ticks after its first tick, and the
// receiver samples data bit k at floor((k + 0.5) * period) after the start edge. The stop
// bit level is not checked. Write the period only while the core is idle.
module uart_8n1_tx_rx_fractional_baud_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [23:0] cfg_wdata,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,  // tx_start, tx_byte[7:0], rx_line, zero pad
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata   // tx_line, tx_busy, rx_valid, rx_byte[7:0], zero pad
);

  logic [uart8n1_pkg::PERIOD_W-1:0] bit_period_q8;

  logic                             tx_active;
  logic [uart8n1_pkg::BYTE_W-1:0]   tx_shift;
  logic [uart8n1_pkg::INDEX_W-1:0]  tx_bit_index;
  logic [uart8n1_pkg::COUNT_W-1:0]  tx_cycle_count;
  logic [uart8n1_pkg::ACC_W-1:0]    tx_boundary_acc;

  logic                             rx_active;
  logic [uart8n1_pkg::BYTE_W-1:0]   rx_shift;
  logic [uart8n1_pkg::INDEX_W-1:0]  rx_bit_index;
  logic [uart8n1_pkg::COUNT_W-1:0]  rx_cycle_count;
  logic [uart8n1_pkg::ACC_W-1:0]    rx_sample_acc;
  logic [uart8n1_pkg::BYTE_W-1:0]   rx_last_byte;

  logic                             tx_active_next;
  logic [uart8n1_pkg::BYTE_W-1:0]   tx_shift_next;
  logic [uart8n1_pkg::INDEX_W-1:0]  tx_bit_index_next;
  logic [uart8n1_pkg::COUNT_W-1:0]  tx_cycle_count_next;
  logic [uart8n1_pkg::ACC_W-1:0]    tx_boundary_acc_next;
  logic                             rx_active_next;
  logic [uart8n1_pkg::BYTE_W-1:0]   rx_shift_next;
  logic [uart8n1_pkg::INDEX_W-1:0]  rx_bit_index_next;
  logic [uart8n1_pkg::COUNT_W-1:0]  rx_cycle_count_next;
  logic [uart8n1_pkg::ACC_W-1:0]    rx_sample_acc_next;
  logic [uart8n1_pkg::BYTE_W-1:0]   rx_last_byte_next;

  logic                             tx_line_next;
  logic                             tx_busy_next;
  logic                             rx_valid_next;

  logic                             in_start;
  logic [uart8n1_pkg::BYTE_W-1:0]   in_byte;
  logic                             in_line;
  logic [uart8n1_pkg::PERIOD_W-1:0] period;
  logic [uart8n1_pkg::ACC_W-1:0]    period_acc;
  logic                             accept;

  assign in_start = s_tdata[0];
  assign in_byte  = s_tdata[8:1];
  assign in_line  = s_tdata[9];

  assign period = (bit_period_q8 < uart8n1_pkg::PERIOD_MIN) ? uart8n1_pkg::PERIOD_MIN
                                                            : bit_period_q8;
  assign period_acc = {4'b0, period};

  assign s_tready = ~m_tvalid | m_tready;
  assign accept   = s_tvalid & s_tready;

  // transmitter tick
  always_comb begin
    logic [uart8n1_pkg::INDEX_W-1:0] data_pos;
    tx_active_next       = tx_active;
    tx_shift_next        = tx_shift;
    tx_bit_index_next    = tx_bit_index;
    tx_cycle_count_next  = tx_cycle_count;
    tx_boundary_acc_next = tx_boundary_acc;
    tx_line_next         = 1'b1;
    tx_busy_next         = 1'b0;
    data_pos             = '0;
    if (!tx_active_next && in_start) begin
      tx_active_next       = 1'b1;
      tx_shift_next        = in_byte;
      tx_bit_index_next    = uart8n1_pkg::START_INDEX;
      tx_cycle_count_next  = '0;
      tx_boundary_acc_next = period_acc;
    end
    if (tx_active_next) begin
      data_pos = tx_bit_index_next - 4'd1;
      if (tx_bit_index_next == uart8n1_pkg::START_INDEX) begin
        tx_line_next = 1'b0;
      end else if (tx_bit_index_next <= uart8n1_pkg::LAST_DATA_IDX) begin
        tx_line_next = (data_pos < 4'd8) ? tx_shift_next[data_pos[2:0]] : 1'b0;
      end else begin
        tx_line_next = 1'b1;
      end
      tx_busy_next        = 1'b1;
      tx_cycle_count_next = tx_cycle_count_next + 20'd1;
      if (tx_cycle_count_next >= tx_boundary_acc_next[27:8]) begin
        tx_bit_index_next = tx_bit_index_next + 4'd1;
        if (tx_bit_index_next > uart8n1_pkg::STOP_INDEX) begin
          tx_active_next    = 1'b0;
          tx_bit_index_next = uart8n1_pkg::START_INDEX;
        end else begin
          tx_boundary_acc_next = tx_boundary_acc_next + period_acc;
        end
      end
    end
  end

  // receiver tick
  always_comb begin
    rx_active_next      = rx_active;
    rx_shift_next       = rx_shift;
    rx_bit_index_next   = rx_bit_index;
    rx_cycle_count_next = rx_cycle_count;
    rx_sample_acc_next  = rx_sample_acc;
    rx_last_byte_next   = rx_last_byte;
    rx_valid_next       = 1'b0;
    if (!rx_active) begin
      if (!in_line) begin
        rx_active_next      = 1'b1;
        rx_shift_next       = '0;
        rx_bit_index_next   = uart8n1_pkg::START_INDEX;
        rx_cycle_count_next = '0;
        rx_sample_acc_next  = period_acc + {5'b0, period[23:1]};
      end
    end else begin
      rx_cycle_count_next = rx_cycle_count + 20'd1;
      if (rx_cycle_count_next >= rx_sample_acc[27:8]) begin
        if (rx_bit_index < uart8n1_pkg::LAST_DATA_IDX) begin
          if (rx_bit_index < 4'd8) begin
            rx_shift_next[rx_bit_index[2:0]] = rx_shift[rx_bit_index[2:0]] | in_line;
          end
          rx_bit_index_next  = rx_bit_index + 4'd1;
          rx_sample_acc_next = rx_sample_acc + period_acc;
          if (rx_bit_index_next == uart8n1_pkg::LAST_DATA_IDX) begin
            rx_last_byte_next = rx_shift_next;
            rx_valid_next     = 1'b1;
          end
        end else begin
          rx_active_next    = 1'b0;
          rx_bit_index_next = uart8n1_pkg::START_INDEX;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bit_period_q8   <= uart8n1_pkg::PERIOD_RESET;
      tx_active       <= 1'b0;
      tx_shift        <= '0;
      tx_bit_index    <= '0;
      tx_cycle_count  <= '0;
      tx_boundary_acc <= '0;
      rx_active       <= 1'b0;
      rx_shift        <= '0;
      rx_bit_index    <= '0;
      rx_cycle_count  <= '0;
      rx_sample_acc   <= '0;
      rx_last_byte    <= '0;
      m_tvalid        <= 1'b0;
    end else begin
      if (cfg_we) begin
        bit_period_q8 <= cfg_wdata;
      end
      if (accept) begin
        tx_active       <= tx_active_next;
        tx_shift        <= tx_shift_next;
        tx_bit_index    <= tx_bit_index_next;
        tx_cycle_count  <= tx_cycle_count_next;
        tx_boundary_acc <= tx_boundary_acc_next;
        rx_active       <= rx_active_next;
        rx_shift        <= rx_shift_next;
        rx_bit_index    <= rx_bit_index_next;
        rx_cycle_count  <= rx_cycle_count_next;
        rx_sample_acc   <= rx_sample_acc_next;
        rx_last_byte    <= rx_last_byte_next;
        m_tvalid        <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (accept) begin
      m_tdata <= {5'b0, rx_last_byte_next, rx_valid_next, tx_busy_next, tx_line_next};
    end
  end

endmodule

// ===== tb/tb_uart_8n1_tx_rx_fractional_baud_core.sv =====
// stream testbench for the 8n1 uart core: per-tick predictor, in-order result check, idle and stall phases
`timescale 1ns / 100ps

module tb_uart_8n1_tx_rx_fractional_baud_core;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned PRINT_CAP   = 50;

  typedef enum logic [1:0] {
    IDLE_NONE,
    IDLE_SEND,
    IDLE_RECV,
    IDLE_BOTH
  } idle_mode_t;

  typedef struct packed {
    logic                          tx_start;
    logic [uart8n1_pkg::BYTE_W-1:0] tx_byte;
    logic                          rx_line;
  } tick_t;

  typedef struct packed {
    logic                          tx_line;
    logic                          tx_busy;
    logic                          rx_valid;
    logic [uart8n1_pkg::BYTE_W-1:0] rx_byte;
  } line_out_t;

  logic                              clk       = 1'b0;
  logic                              rst       = 1'b1;
  logic                              cfg_we    = 1'b0;
  logic [uart8n1_pkg::PERIOD_W-1:0]   cfg_wdata = '0;
  logic                              s_tvalid  = 1'b0;
  logic                              s_tready;
  logic [uart8n1_pkg::IN_DATA_W-1:0]  s_tdata   = '0;
  logic                              m_tvalid;
  logic                              m_tready  = 1'b0;
  logic [uart8n1_pkg::OUT_DATA_W-1:0] m_tdata;

  // predictor state
  logic [uart8n1_pkg::PERIOD_W-1:0] period_cfg = uart8n1_pkg::PERIOD_RESET;
  logic                            tx_on      = 1'b0;
  logic [uart8n1_pkg::BYTE_W-1:0]   tx_sr      = '0;
  logic [uart8n1_pkg::INDEX_W-1:0]  tx_idx     = '0;
  logic [uart8n1_pkg::COUNT_W-1:0]  tx_cnt     = '0;
  logic [uart8n1_pkg::ACC_W-1:0]    tx_acc     = '0;
  logic                            rx_on      = 1'b0;
  logic [uart8n1_pkg::BYTE_W-1:0]   rx_sr      = '0;
  logic [uart8n1_pkg::INDEX_W-1:0]  rx_idx     = '0;
  logic [uart8n1_pkg::COUNT_W-1:0]  rx_cnt     = '0;
  logic [uart8n1_pkg::ACC_W-1:0]    rx_acc     = '0;
  logic [uart8n1_pkg::BYTE_W-1:0]   rx_held    = '0;

  tick_t       pending_ticks[$];
  line_out_t   expected_lines[$];
  tick_t       offered;
  idle_mode_t  idle_mode      = IDLE_NONE;
  logic        hold_arm       = 1'b0;
  int unsigned hold_left      = 0;
  int unsigned mismatch_count = 0;
  int unsigned cycle_count    = 0;

  uart_8n1_tx_rx_fractional_baud_core DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),   // tx_start, tx_byte[7:0], rx_line, zero pad
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)    // tx_line, tx_busy, rx_valid, rx_byte[7:0], zero pad
  );

  always #4 clk = ~clk;

  function automatic line_out_t uart_tick(input tick_t t);
    logic [uart8n1_pkg::PERIOD_W-1:0] p;
    logic [uart8n1_pkg::INDEX_W-1:0]  d;
    line_out_t                       r;
    p = (period_cfg < uart8n1_pkg::PERIOD_MIN) ? uart8n1_pkg::PERIOD_MIN : period_cfg;
    r = '{tx_line: 1'b1, tx_busy: 1'b0, rx_valid: 1'b0, rx_byte: '0};

    if (!tx_on && t.tx_start) begin
      tx_on  = 1'b1;
      tx_sr  = t.tx_byte;
      tx_idx = uart8n1_pkg::START_INDEX;
      tx_cnt = '0;
      tx_acc = uart8n1_pkg::ACC_W'(p);
    end
    if (tx_on) begin
      if (tx_idx == uart8n1_pkg::START_INDEX) begin
        r.tx_line = 1'b0;
      end else if (tx_idx <= uart8n1_pkg::LAST_DATA_IDX) begin
        d = tx_idx - 1'b1;
        r.tx_line = (d < uart8n1_pkg::BYTE_W) ? tx_sr[d[2:0]] : 1'b0;
      end
      r.tx_busy = 1'b1;
      tx_cnt = tx_cnt + 1'b1;
      if (tx_cnt >= tx_acc[uart8n1_pkg::ACC_W-1:8]) begin
        tx_idx = tx_idx + 1'b1;
        if (tx_idx > uart8n1_pkg::STOP_INDEX) begin
          tx_on  = 1'b0;
          tx_idx = uart8n1_pkg::START_INDEX;
        end else begin
          tx_acc = tx_acc + uart8n1_pkg::ACC_W'(p);
        end
      end
    end

    if (!rx_on) begin
      if (!t.rx_line) begin
        rx_on  = 1'b1;
        rx_sr  = '0;
        rx_idx = uart8n1_pkg::START_INDEX;
        rx_cnt = '0;
        rx_acc = uart8n1_pkg::ACC_W'(p) + uart8n1_pkg::ACC_W'(p >> 1);
      end
    end else begin
      rx_cnt = rx_cnt + 1'b1;
      if (rx_cnt >= rx_acc[uart8n1_pkg::ACC_W-1:8]) begin
        if (rx_idx < uart8n1_pkg::LAST_DATA_IDX) begin
          if (rx_idx < uart8n1_pkg::BYTE_W)
            rx_sr[rx_idx[2:0]] = rx_sr[rx_idx[2:0]] | t.rx_line;
          rx_idx = rx_idx + 1'b1;
          rx_acc = rx_acc + uart8n1_pkg::ACC_W'(p);
          if (rx_idx == uart8n1_pkg::LAST_DATA_IDX) begin
            rx_held    = rx_sr;
            r.rx_valid = 1'b1;
          end
        end else begin
          rx_on  = 1'b0;
          rx_idx = uart8n1_pkg::START_INDEX;
        end
      end
    end
    r.rx_byte = rx_held;
    return r;
  endfunction

  function automatic bit sender_idle();
    case (idle_mode)
      IDLE_SEND: return $urandom_range(99) < 78;
      IDLE_BOTH: return $urandom_range(99) < 30;
      default:   return 1'b0;
    endcase
  endfunction

  function automatic bit receiver_stall();
    case (idle_mode)
      IDLE_RECV: return $urandom_range(99) < 78;
      IDLE_BOTH: return $urandom_range(99) < 30;
      default:   return 1'b0;
    endcase
  endfunction

  task automatic report_mismatch(input string what, input logic [7:0] got, input logic [7:0] want);
    if (mismatch_count < PRINT_CAP)
      $display("%0t ns: %s mismatch, got %0h want %0h", $time, what, got, want);
    mismatch_count++;
  endtask

  task automatic push_tick(input logic start, input logic [uart8n1_pkg::BYTE_W-1:0] b,
                           input logic lvl);
    tick_t t;
    t.tx_start = start;
    t.tx_byte  = b;
    t.rx_line  = lvl;
    pending_ticks.push_back(t);
  endtask

  // one frame at one tick per bit, start held high so the busy transmitter ignores it
  task automatic push_frame(input logic [uart8n1_pkg::BYTE_W-1:0] tx_b,
                            input logic [uart8n1_pkg::BYTE_W-1:0] rx_b,
                            input logic stop_lvl);
    push_tick(1'b1, tx_b, 1'b0);
    for (int k = 0; k < uart8n1_pkg::BYTE_W; k++)
      push_tick(1'b1, uart8n1_pkg::BYTE_W'($urandom), rx_b[k]);
    push_tick(1'b1, uart8n1_pkg::BYTE_W'($urandom), stop_lvl);
  endtask

  // rx line carries frames timed from the current period, with noise and low stop bits mixed in
  task automatic queue_stream(input int unsigned n_ticks);
    longint unsigned pe;
    longint unsigned edge_at;
    logic [9:0]      frame;
    int unsigned     bit_no;
    int unsigned     pos;
    int unsigned     gap;
    int unsigned     i;
    int unsigned     r;
    logic            lvl;
    pe      = (period_cfg < uart8n1_pkg::PERIOD_MIN) ? uart8n1_pkg::PERIOD_MIN : period_cfg;
    bit_no  = 10;
    gap     = 0;
    pos     = 0;
    edge_at = 0;
    frame   = '1;
    for (i = 0; i < n_ticks; i++) begin
      if (bit_no >= 10 && gap == 0) begin
        r = $urandom_range(99);
        if (r < 12)
          frame = 10'($urandom);
        else
          frame = {(r < 22) ? 1'b0 : 1'b1, uart8n1_pkg::BYTE_W'($urandom), 1'b0};
        bit_no  = 0;
        pos     = 0;
        edge_at = pe >> 8;
        gap     = $urandom_range(0, 3) * int'(pe >> 8);
      end
      if (bit_no < 10) begin
        lvl = frame[bit_no];
      end else begin
        lvl = 1'b1;
        gap--;
      end
      push_tick($urandom_range(99) < 12, uart8n1_pkg::BYTE_W'($urandom), lvl);
      pos++;
      if (bit_no < 10 && pos >= edge_at) begin
        bit_no++;
        edge_at = (longint'(bit_no + 1) * pe) >> 8;
      end
    end
  endtask

  task automatic drain();
    @(negedge clk);
    while (pending_ticks.size() != 0 || s_tvalid || expected_lines.size() != 0)
      @(negedge clk);
  endtask

  task automatic run_phase(input logic [uart8n1_pkg::PERIOD_W-1:0] period,
                           input int unsigned n_ticks,
                           input idle_mode_t mode, input bit pressure);
    drain();
    repeat (4) @(posedge clk);
    cfg_we     <= 1'b1;
    cfg_wdata  <= period;
    period_cfg  = period;
    @(posedge clk);
    cfg_we    <= 1'b0;
    idle_mode  = mode;
    if (pressure)
      hold_arm <= 1'b1;
    queue_stream(n_ticks);
    if (pressure) begin
      @(posedge clk);
      hold_arm <= 1'b0;
    end
  endtask

  // request driver
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready)
        expected_lines.push_back(uart_tick(offered));
      if (!s_tvalid || s_tready) begin
        if (pending_ticks.size() != 0 && !sender_idle()) begin
          offered   = pending_ticks.pop_front();
          s_tvalid <= 1'b1;
          s_tdata  <= {6'd0, offered.rx_line, offered.tx_byte, offered.tx_start};
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-off
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
    end else if (hold_arm && hold_left == 0) begin
      hold_left <= HOLD_CYCLES;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // result monitor
  always @(posedge clk) begin : result_check
    line_out_t want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (expected_lines.size() == 0) begin
          report_mismatch("unexpected result", m_tdata[10:3], '0);
        end else begin
          want = expected_lines.pop_front();
          if (m_tdata[0] !== want.tx_line)
            report_mismatch("tx_line", 8'(m_tdata[0]), 8'(want.tx_line));
          if (m_tdata[1] !== want.tx_busy)
            report_mismatch("tx_busy", 8'(m_tdata[1]), 8'(want.tx_busy));
          if (m_tdata[2] !== want.rx_valid)
            report_mismatch("rx_valid", 8'(m_tdata[2]), 8'(want.rx_valid));
          if (m_tdata[10:3] !== want.rx_byte)
            report_mismatch("rx_byte", m_tdata[10:3], want.rx_byte);
        end
      end
      m_tready <= (hold_left == 0) && !receiver_stall();
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset period: first transmit bit boundary; the stream ends before the first receive sample
    idle_mode = IDLE_NONE;
    queue_stream(150);

    // one tick per bit: byte extremes, start while busy, a frame with a low stop bit
    run_phase(24'd256, 0, IDLE_NONE, 1'b0);
    push_frame(8'hFF, 8'h00, 1'b1);
    push_frame(8'h00, 8'hFF, 1'b0);
    push_tick(1'b0, 8'h5A, 1'b0);
    push_tick(1'b0, 8'hA5, 1'b1);
    push_tick(1'b1, 8'h80, 1'b1);

    run_phase(24'd0, 80, IDLE_NONE, 1'b0);
    run_phase(24'd17, 40, IDLE_SEND, 1'b0);
    run_phase(24'd300, 80, IDLE_RECV, 1'b0);
    run_phase(24'd383, 80, IDLE_BOTH, 1'b0);
    run_phase(24'd512, 80, IDLE_NONE, 1'b1);
    run_phase(24'd700, 80, IDLE_SEND, 1'b0);
    run_phase(24'd1000, 60, IDLE_BOTH, 1'b0);
    run_phase(24'hFFFFFF, 40, IDLE_RECV, 1'b0);
    run_phase(24'd257, 80, IDLE_NONE, 1'b0);

    drain();
    repeat (20) @(posedge clk);
    if (expected_lines.size() != 0)
      report_mismatch("results never arrived", 8'(expected_lines.size()), '0);

    if (mismatch_count == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/uart8n1_pkg.sv
rtl/uart_8n1_tx_rx_fractional_baud_core.sv
tb/tb_uart_8n1_tx_rx_fractional_baud_core.sv
